// File: rtl/wsp_pkg.sv
// Package for the wind sentence parser: beat types, phase encoding and character constants.
package wsp_pkg;

  localparam int unsigned MaxBytesDefault = 63;
  localparam int unsigned SpeedW          = 16;
  localparam int unsigned HeadingW        = 9;
  localparam int unsigned HeadingMax      = 359;

  localparam logic [7:0] ChrW     = 8'h57;  // 'W'
  localparam logic [7:0] ChrN     = 8'h4E;  // 'N'
  localparam logic [7:0] ChrI     = 8'h49;  // 'I'
  localparam logic [7:0] ChrComma = 8'h2C;  // ','
  localparam logic [7:0] ChrDot   = 8'h2E;  // '.'
  localparam logic [7:0] ChrZero  = 8'h30;  // '0'
  localparam logic [7:0] ChrNine  = 8'h39;  // '9'

  typedef enum logic [0:0] {
    ActData = 1'b0,
    ActEnd  = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    PhHunt  = 3'd0,
    PhInt   = 3'd1,
    PhFrac  = 3'd2,
    PhComma = 3'd3,
    PhDir   = 3'd4,
    PhOk    = 3'd5,
    PhFail  = 3'd6
  } phase_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic                sample_ok;
    logic [SpeedW-1:0]   speed_tenths;
    logic [HeadingW-1:0] heading_deg;
  } out_beat_t;

  // Expected character at each position of the marker.
  function automatic logic [7:0] marker_char(input logic [1:0] idx);
    logic [7:0] chr;
    unique case (idx)
      2'd0:    chr = ChrW;
      2'd1:    chr = ChrN;
      2'd2:    chr = ChrI;
      default: chr = ChrComma;
    endcase
    return chr;
  endfunction

  function automatic logic is_digit(input logic [7:0] chr);
    return (chr >= ChrZero) && (chr <= ChrNine);
  endfunction

endpackage

// File: rtl/wind_sentence_parser.sv
// Wind sentence parser: per-byte marker hunt, speed and heading parse, one result per response.
// The result beat is registered and shown in the cycle after the end-of-response beat is accepted.
// Throughput: one input beat per cycle; each data byte updates the parse state as it is accepted.
// The input stalls only while an undelivered result sits in the output register and the
// downstream side stalls it.
// Reset (asynchronous, active low) returns the parser to marker hunting and empties the output.
module wind_sentence_parser
  import wsp_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MaxBytesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_BYTES + 1);

  phase_e              phase_q, phase_d;
  logic [1:0]          mark_q, mark_d;
  logic [SpeedW-1:0]   speed_q, speed_d;
  logic [HeadingW-1:0] heading_q, heading_d;
  logic                over_q, over_d;
  logic [CntW-1:0]     seen_q, seen_d;

  logic      out_valid_q, out_valid_d;
  out_beat_t out_data_q, out_data_d;

  logic              accept;
  logic              end_take;
  logic              byte_take;
  logic [7:0]        chr;
  logic              chr_digit;
  logic [3:0]        digit;
  logic [SpeedW-1:0] speed_scaled;
  logic [11:0]       heading_ext;
  logic [11:0]       heading_v;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign end_take   = accept && (in_data_i.action == ActEnd);
  assign byte_take  = accept && (in_data_i.action == ActData) &&
                      (seen_q < CntW'(MAX_BYTES));

  assign chr          = in_data_i.rx_byte;
  assign chr_digit    = is_digit(chr);
  assign digit        = chr[3:0];
  assign speed_scaled = (speed_q << 3) + (speed_q << 1);
  assign heading_ext  = {3'b000, heading_q};
  assign heading_v    = (heading_ext << 3) + (heading_ext << 1) + {8'h00, digit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      mark_q      <= '0;
      speed_q     <= '0;
      heading_q   <= '0;
      over_q      <= 1'b0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      mark_q      <= mark_d;
      speed_q     <= speed_d;
      heading_q   <= heading_d;
      over_q      <= over_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  always_comb begin
    phase_d     = phase_q;
    mark_d      = mark_q;
    speed_d     = speed_q;
    heading_d   = heading_q;
    over_d      = over_q;
    seen_d      = seen_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (end_take) begin
      // End of response acts as a NUL: only a sentence that has reached the heading field survives it.
      out_valid_d = 1'b1;
      if ((phase_q == PhDir) || (phase_q == PhOk)) begin
        out_data_d.sample_ok    = 1'b1;
        out_data_d.speed_tenths = speed_q;
        out_data_d.heading_deg  = over_q ? '0 : heading_q;
      end else begin
        out_data_d = '0;
      end
      phase_d   = PhHunt;
      mark_d    = '0;
      speed_d   = '0;
      heading_d = '0;
      over_d    = 1'b0;
      seen_d    = '0;
    end else if (byte_take) begin
      seen_d = seen_q + CntW'(1);
      unique case (phase_q)
        PhHunt: begin
          if (chr == marker_char(mark_q)) begin
            if (mark_q == 2'd3) begin
              mark_d  = '0;
              phase_d = PhInt;
            end else begin
              mark_d = mark_q + 2'd1;
            end
          end else begin
            // Restart the match, keeping a 'W' as a fresh first character.
            mark_d = (chr == ChrW) ? 2'd1 : 2'd0;
          end
        end
        PhInt: begin
          if (chr_digit) begin
            speed_d = speed_scaled + {12'h000, digit};
          end else begin
            speed_d = speed_scaled;
            priority if (chr == ChrDot) begin
              phase_d = PhFrac;
            end else if (chr == ChrComma) begin
              phase_d = PhDir;
            end else begin
              phase_d = PhFail;
            end
          end
        end
        PhFrac: begin
          if (chr_digit) begin
            speed_d = speed_q + {12'h000, digit};
            phase_d = PhComma;
          end else begin
            phase_d = (chr == ChrComma) ? PhDir : PhFail;
          end
        end
        PhComma: begin
          phase_d = (chr == ChrComma) ? PhDir : PhFail;
        end
        PhDir: begin
          if (chr_digit) begin
            if (!over_q) begin
              if (heading_v > 12'(HeadingMax)) begin
                over_d = 1'b1;
              end else begin
                heading_d = heading_v[HeadingW-1:0];
              end
            end
          end else begin
            phase_d = PhOk;
          end
        end
        default: begin
          // Done or failed: drop further bytes.
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.sample_ok) |->
      (out_data_o.speed_tenths == '0 && out_data_o.heading_deg == '0))
    else $error("failed sample carries non-zero fields");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.heading_deg <= HeadingW'(HeadingMax)))
    else $error("heading out of range");

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_take |=> (phase_q == PhHunt && seen_q == '0 && mark_q == '0 && out_valid_q))
    else $error("end beat did not restart the parser");

  a_seen_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= CntW'(MAX_BYTES))
    else $error("byte count past limit");

  a_heading_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (over_q && !end_take) |=> (over_q && $stable(heading_q)))
    else $error("heading changed after overflow");

endmodule

// File: tb/wind_sentence_parser_tb.sv
// Self-checking testbench for the wind sentence parser: directed and random responses vs a local model.
`timescale 1ns / 100ps

module wind_sentence_parser_tb;
  import wsp_pkg::*;

  localparam int unsigned ByteLimit = MaxBytesDefault;
  localparam logic [31:0] MarkerSeq = {ChrComma, ChrI, ChrN, ChrW};
  localparam int unsigned QuietFrom = 900;
  localparam int unsigned QuietTo   = 1700;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_data_o;

  wind_sentence_parser #(
    .MAX_BYTES(ByteLimit)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  in_beat_t    pending_beats[$];
  out_beat_t   expected_reports[$];
  int unsigned beats_queued = 0;
  int unsigned beats_taken  = 0;
  int unsigned cycle_no     = 0;
  int unsigned mismatches   = 0;
  bit          in_taken     = 1'b0;

  // Local copy of the parser state
  phase_e      sp_phase;
  logic [1:0]  sp_marker;
  logic [15:0] sp_speed;
  logic [8:0]  sp_heading;
  logic        sp_over;
  int unsigned sp_count;

  function automatic void restart_parse();
    sp_phase   = PhHunt;
    sp_marker  = 2'd0;
    sp_speed   = '0;
    sp_heading = '0;
    sp_over    = 1'b0;
    sp_count   = 0;
  endfunction

  function automatic bit numeral(input logic [7:0] chr);
    return (chr >= ChrZero) && (chr <= ChrNine);
  endfunction

  function automatic void parse_char(input logic [7:0] chr);
    int unsigned acc;
    case (sp_phase)
      PhHunt: begin
        if (chr == MarkerSeq[sp_marker*8 +: 8]) begin
          if (sp_marker == 2'd3) begin
            sp_marker = 2'd0;
            sp_phase  = PhInt;
          end else begin
            sp_marker = sp_marker + 2'd1;
          end
        end else begin
          // a stray 'W' may open a fresh marker
          sp_marker = (chr == ChrW) ? 2'd1 : 2'd0;
        end
      end
      PhInt: begin
        if (numeral(chr)) begin
          sp_speed = 16'(sp_speed * 10 + (chr - ChrZero));
        end else begin
          sp_speed = 16'(sp_speed * 10);
          if (chr == ChrDot) sp_phase = PhFrac;
          else if (chr == ChrComma) sp_phase = PhDir;
          else sp_phase = PhFail;
        end
      end
      PhFrac: begin
        if (numeral(chr)) begin
          sp_speed = 16'(sp_speed + (chr - ChrZero));
          sp_phase = PhComma;
        end else begin
          sp_phase = (chr == ChrComma) ? PhDir : PhFail;
        end
      end
      PhComma: begin
        sp_phase = (chr == ChrComma) ? PhDir : PhFail;
      end
      PhDir: begin
        if (numeral(chr)) begin
          if (!sp_over) begin
            acc = sp_heading * 10 + (chr - ChrZero);
            if (acc > HeadingMax) sp_over = 1'b1;
            else sp_heading = acc[8:0];
          end
        end else begin
          sp_phase = PhOk;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void predict_beat(input in_beat_t beat);
    out_beat_t rep;
    if (beat.action == ActData) begin
      // drop bytes past the buffer limit
      if (sp_count < ByteLimit) begin
        sp_count++;
        parse_char(beat.rx_byte);
      end
    end else begin
      parse_char(8'h00);
      rep = '0;
      if (sp_phase == PhOk) begin
        rep.sample_ok    = 1'b1;
        rep.speed_tenths = sp_speed;
        rep.heading_deg  = sp_over ? '0 : sp_heading;
      end
      expected_reports.push_back(rep);
      restart_parse();
    end
  endfunction

  function automatic void check_field(input string label, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      mismatches++;
    end
  endfunction

  function automatic bit idle_roll();
    return (cycle_no < QuietFrom || cycle_no >= QuietTo) && ($urandom_range(99) < 11);
  endfunction

  function automatic logic [7:0] rand_digit();
    return ChrZero + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_char();
    logic [7:0] chr;
    case ($urandom_range(7))
      0:       chr = rand_digit();
      1:       chr = ChrDot;
      2:       chr = ChrComma;
      3:       chr = ChrW;
      4:       chr = ChrN;
      5:       chr = ChrI;
      default: chr = 8'($urandom_range(255));
    endcase
    return chr;
  endfunction

  task automatic queue_beat(input action_e act, input logic [7:0] chr);
    in_beat_t beat;
    beat.action  = act;
    beat.rx_byte = chr;
    pending_beats.push_back(beat);
    beats_queued++;
  endtask

  task automatic queue_text(input string text);
    for (int i = 0; i < text.len(); i++) queue_beat(ActData, text[i]);
  endtask

  // Mostly well-formed sentences with random content; some noise, some corrupted.
  task automatic queue_response();
    logic [7:0]  body[$];
    int unsigned kind;
    int unsigned n;
    int unsigned pos;
    kind = $urandom_range(99);
    if (kind < 8) begin
      n = $urandom_range(12);
      repeat (n) body.push_back(rand_char());
    end else begin
      // a long preamble pushes the marker towards or past the buffer limit
      n = (kind < 12) ? $urandom_range(70, 40) : $urandom_range(3);
      repeat (n) body.push_back(rand_char());
      for (int i = 0; i < 4; i++) body.push_back(MarkerSeq[i*8 +: 8]);
      n = ($urandom_range(7) == 0) ? $urandom_range(9, 5) : $urandom_range(3);
      repeat (n) body.push_back(rand_digit());
      if ($urandom_range(1)) begin
        body.push_back(ChrDot);
        if ($urandom_range(3) != 0) body.push_back(rand_digit());
      end
      body.push_back(ChrComma);
      n = $urandom_range(4);
      repeat (n) body.push_back(rand_digit());
      n = $urandom_range(2);
      repeat (n) body.push_back(rand_char());
      if (kind < 24) begin
        pos = $urandom_range(body.size() - 1);
        body[pos] = rand_char();
      end
    end
    foreach (body[i]) queue_beat(ActData, body[i]);
    queue_beat(ActEnd, 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (beats_taken != beats_queued || expected_reports.size() != 0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    cycle_no++;
    // advance only once the current beat has gone
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_beats.size() != 0 && !idle_roll()) begin
        in_data_i  <= pending_beats.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= idle_roll();
  end

  always @(posedge clk_i) begin : monitor
    out_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual %h", $time, out_data_o);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("sample_ok", want.sample_ok, out_data_o.sample_ok);
          check_field("speed_tenths", want.speed_tenths, out_data_o.speed_tenths);
          check_field("heading_deg", want.heading_deg, out_data_o.heading_deg);
        end
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        beats_taken++;
        predict_beat(in_data_i);
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    restart_parse();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // end with nothing before it: no marker
    queue_beat(ActEnd, 8'h00);
    // zero byte, all-ones byte, dot without digit, empty direction
    queue_beat(ActData, 8'h00);
    queue_beat(ActData, 8'hFF);
    queue_text("WNI,.,");
    queue_beat(ActEnd, 8'h00);
    // direction above 359
    queue_text("WNI,1,400");
    queue_beat(ActEnd, 8'hFF);
    // bad separator after the speed
    queue_text("WNI,3x");
    queue_beat(ActEnd, 8'h00);

    while (beats_queued < 1000) queue_response();
    // hold the sender until every report is back
    wait_drained();
    while (beats_queued < 2000) queue_response();
    wait_drained();
    repeat (4) @(negedge clk_i);

    if (expected_reports.size() == 0 && mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: wind_sentence_parser.f
rtl/wsp_pkg.sv
rtl/wind_sentence_parser.sv
tb/wind_sentence_parser_tb.sv
